### hdl/itpe_pkg.sv
// shared constants, types and byte helpers for the interval timer port block
`default_nettype none
package itpe_pkg;

    localparam int unsigned REQ_W  = 2;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned MODE_W = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // access field, mode bits 5..4
    typedef enum logic [1:0] {
        ACC_LATCH = 2'd0,
        ACC_LOW   = 2'd1,
        ACC_HIGH  = 2'd2,
        ACC_ALT   = 2'd3
    } t_acc;

    // control byte selector, bits 7..6
    typedef enum logic [1:0] {
        SEL_CNT0 = 2'd0,
        SEL_CNT1 = 2'd1,
        SEL_CNT2 = 2'd2,
        SEL_RB   = 2'd3
    } t_sel;

    localparam logic [PORT_W-1:0] PORT_CNT0 = 16'h0040;
    localparam logic [PORT_W-1:0] PORT_CNT2 = 16'h0042;
    localparam logic [PORT_W-1:0] PORT_CTRL = 16'h0043;
    localparam logic [PORT_W-1:0] PORT_B    = 16'h0061;
    localparam logic [BYTE_W-1:0] MODE_MASK = 8'h3f;
    localparam logic [CNT_W-1:0]  HIGH_MASK = 16'hff00;

    function automatic t_acc acc_of(input logic [MODE_W-1:0] mode);
        return t_acc'(mode[5:4]);
    endfunction

    function automatic logic [CNT_W-1:0] load_byte(
        input logic [CNT_W-1:0]  reload,
        input logic [MODE_W-1:0] mode,
        input logic              toggle,
        input logic [BYTE_W-1:0] din
    );
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        lo = (reload & HIGH_MASK) | {8'h00, din};
        hi = (reload & ~HIGH_MASK) | {din, 8'h00};
        case (acc_of(mode))
            ACC_LOW:  return lo;
            ACC_HIGH: return hi;
            ACC_ALT:  return toggle ? hi : lo;
            default:  return reload;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] read_byte(
        input logic [CNT_W-1:0]  value,
        input logic [MODE_W-1:0] mode,
        input logic              toggle
    );
        case (acc_of(mode))
            ACC_LOW:  return value[7:0];
            ACC_HIGH: return value[15:8];
            ACC_ALT:  return toggle ? value[15:8] : value[7:0];
            default:  return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

### hdl/itpe_ifs.sv
// valid/ready channel interfaces for bus access items and read results
`default_nettype none
interface itpe_in_if;
    logic                          valid;
    logic                          ready;
    logic [itpe_pkg::REQ_W-1:0]    req_type;
    logic [itpe_pkg::PORT_W-1:0]   port;
    logic [itpe_pkg::BYTE_W-1:0]   data;
    logic                          byte_sized;

    modport source (output valid, req_type, port, data, byte_sized, input ready);
    modport sink   (input valid, req_type, port, data, byte_sized, output ready);
endinterface

interface itpe_out_if;
    logic                          valid;
    logic                          ready;
    logic [itpe_pkg::BYTE_W-1:0]   read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface
`default_nettype wire

### hdl/interval_timer_port_emulation.sv
// top level: interval timer with counter 0, counter 2, control port and port b
//
//   channel  dir  signals                                  role
//   i_in     in   req_type, port, data, byte_sized         bus access or tick
//   o_out    out  read_data                                one byte per item
//
// one item per cycle sustained while o_out does not stall; each item passes through the
// input register and then the result register, updated by the single state update stage
// reset (i_rst_n low, synchronous) clears all timer state and both stages
// input stays ready while a result waits, as long as the input register can move
// a stall on o_out holds the result and backs up into the input register
`default_nettype none
module interval_timer_port_emulation (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    itpe_in_if.sink    i_in,
    itpe_out_if.source o_out
);

    // input register
    logic                               r_s1_valid;
    itpe_pkg::t_req                     r_s1_req;
    logic [itpe_pkg::PORT_W-1:0]        r_s1_port;
    logic [itpe_pkg::BYTE_W-1:0]        r_s1_data;
    logic                               r_s1_bytes;

    // result register
    logic                               r_out_valid;
    logic [itpe_pkg::BYTE_W-1:0]        r_out_data;

    // timer state
    logic [itpe_pkg::CNT_W-1:0]  r_now,     n_now;
    logic [itpe_pkg::BYTE_W-1:0] r_ctrl,    n_ctrl;
    logic [itpe_pkg::MODE_W-1:0] r_mode0,   n_mode0;
    logic [itpe_pkg::MODE_W-1:0] r_mode2,   n_mode2;
    logic                        r_tog0,    n_tog0;
    logic                        r_tog2,    n_tog2;
    logic [itpe_pkg::CNT_W-1:0]  r_reload0, n_reload0;
    logic [itpe_pkg::CNT_W-1:0]  r_reload2, n_reload2;
    logic [itpe_pkg::CNT_W-1:0]  r_start0,  n_start0;
    logic [itpe_pkg::CNT_W-1:0]  r_start2,  n_start2;
    logic [itpe_pkg::CNT_W-1:0]  r_stop2,   n_stop2;
    logic                        r_gate2,   n_gate2;

    logic                        s1_adv;
    logic [itpe_pkg::BYTE_W-1:0] rd;
    logic [itpe_pkg::CNT_W-1:0]  val0;
    logic [itpe_pkg::CNT_W-1:0]  val2;
    logic [itpe_pkg::CNT_W-1:0]  t2;
    logic                        alt0;
    logic                        alt2;
    itpe_pkg::t_sel              sel;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

    // counters count up from the reload value
    assign t2   = r_gate2 ? r_now : r_stop2;
    assign val0 = r_reload0 + (r_now - r_start0);
    assign val2 = r_reload2 + (t2 - r_start2);
    assign alt0 = itpe_pkg::acc_of(r_mode0) == itpe_pkg::ACC_ALT;
    assign alt2 = itpe_pkg::acc_of(r_mode2) == itpe_pkg::ACC_ALT;
    assign sel  = itpe_pkg::t_sel'(r_s1_data[7:6]);

    always_comb begin
        n_now     = r_now;
        n_ctrl    = r_ctrl;
        n_mode0   = r_mode0;
        n_mode2   = r_mode2;
        n_tog0    = r_tog0;
        n_tog2    = r_tog2;
        n_reload0 = r_reload0;
        n_reload2 = r_reload2;
        n_start0  = r_start0;
        n_start2  = r_start2;
        n_stop2   = r_stop2;
        n_gate2   = r_gate2;
        rd        = '0;
        if (s1_adv) begin
            if (r_s1_req == itpe_pkg::REQ_TICK) begin
                n_now = r_now + 16'd1;
            end else if ((r_s1_req == itpe_pkg::REQ_READ || r_s1_req == itpe_pkg::REQ_WRITE)
                         && r_s1_bytes) begin
                case (r_s1_port)
                    itpe_pkg::PORT_CNT0: begin
                        n_tog0 = r_tog0 ^ alt0;
                        if (r_s1_req == itpe_pkg::REQ_WRITE) begin
                            n_reload0 = itpe_pkg::load_byte(r_reload0, r_mode0, r_tog0,
                                                            r_s1_data);
                            n_start0  = r_now;
                        end else begin
                            rd = itpe_pkg::read_byte(val0, r_mode0, r_tog0);
                        end
                    end
                    itpe_pkg::PORT_CNT2: begin
                        n_tog2 = r_tog2 ^ alt2;
                        if (r_s1_req == itpe_pkg::REQ_WRITE) begin
                            n_reload2 = itpe_pkg::load_byte(r_reload2, r_mode2, r_tog2,
                                                            r_s1_data);
                            if (r_gate2) begin
                                n_start2 = r_now;
                            end
                        end else begin
                            rd = itpe_pkg::read_byte(val2, r_mode2, r_tog2);
                        end
                    end
                    itpe_pkg::PORT_CTRL: begin
                        if (r_s1_req == itpe_pkg::REQ_WRITE) begin
                            n_ctrl = r_s1_data;
                            case (sel)
                                itpe_pkg::SEL_CNT0: begin
                                    n_mode0 = r_s1_data[itpe_pkg::MODE_W-1:0];
                                    n_tog0  = 1'b0;
                                end
                                itpe_pkg::SEL_CNT2: begin
                                    n_mode2 = r_s1_data[itpe_pkg::MODE_W-1:0];
                                    n_tog2  = 1'b0;
                                end
                                default: ;
                            endcase
                        end else begin
                            rd = r_ctrl;
                        end
                    end
                    itpe_pkg::PORT_B: begin
                        if (r_s1_req == itpe_pkg::REQ_WRITE) begin
                            // gate edges only; same level is a no-op
                            if (r_s1_data[0] && !r_gate2) begin
                                n_start2 = r_now;
                                n_gate2  = 1'b1;
                            end else if (!r_s1_data[0] && r_gate2) begin
                                n_stop2 = r_now;
                                n_gate2 = 1'b0;
                            end
                        end else begin
                            rd = {7'd0, r_gate2};
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_now       <= '0;
            r_ctrl      <= '0;
            r_mode0     <= '0;
            r_mode2     <= '0;
            r_tog0      <= 1'b0;
            r_tog2      <= 1'b0;
            r_reload0   <= '0;
            r_reload2   <= '0;
            r_start0    <= '0;
            r_start2    <= '0;
            r_stop2     <= '0;
            r_gate2     <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_now     <= n_now;
            r_ctrl    <= n_ctrl;
            r_mode0   <= n_mode0;
            r_mode2   <= n_mode2;
            r_tog0    <= n_tog0;
            r_tog2    <= n_tog2;
            r_reload0 <= n_reload0;
            r_reload2 <= n_reload2;
            r_start0  <= n_start0;
            r_start2  <= n_start2;
            r_stop2   <= n_stop2;
            r_gate2   <= n_gate2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_req   <= itpe_pkg::t_req'(i_in.req_type);
            r_s1_port  <= i_in.port;
            r_s1_data  <= i_in.data;
            r_s1_bytes <= i_in.byte_sized;
        end
        if (s1_adv) begin
            r_out_data <= rd;
        end
    end

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_req == itpe_pkg::REQ_TICK |=> r_now == $past(r_now) + 16'd1)
        else $error("tick item did not advance the tick count");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_req != itpe_pkg::REQ_READ |=> r_out_data == '0)
        else $error("non-read item returned nonzero data");

    a_portb_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_port == itpe_pkg::PORT_B |=> r_out_data[7:1] == 7'd0)
        else $error("port b result has upper bits set");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_valid && r_out_valid && !o_out.ready)
        else $error("input stalled while a stage was free");

    a_gate_off_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gate2 && !$past(r_gate2) |-> $stable(r_stop2))
        else $error("stop time moved while gate stayed off");

endmodule
`default_nettype wire

### verif/tb_interval_timer_port_emulation.sv
// testbench for the interval timer port block: directed and random bus traffic, checked
`timescale 1ns / 1ps
module tb_interval_timer_port_emulation;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int CNT0_IDX       = 0;
    localparam int CNT2_IDX       = 1;

    logic i_clk;
    logic i_rst_n;

    itpe_in_if  in_ch ();
    itpe_out_if out_ch ();

    interval_timer_port_emulation u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // timer state as seen from the bus, index 0 is counter 0 and index 1 counter 2
    logic [15:0] tm_now     = '0;
    logic [7:0]  tm_ctrl    = '0;
    logic [5:0]  tm_mode  [2] = '{default: '0};
    logic        tm_tog   [2] = '{default: 1'b0};
    logic [15:0] tm_reload[2] = '{default: '0};
    logic [15:0] tm_start [2] = '{default: '0};
    logic [15:0] tm_stop    = '0;
    logic        tm_gate    = 1'b0;

    logic [7:0] read_data_q[$];
    int         fail_count    = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    logic       hold_armed    = 1'b0;
    logic       hold_taken    = 1'b0;
    int         hold_left     = 0;
    int         stall_cycles  = 0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] ctrl_word(itpe_pkg::t_sel sel, itpe_pkg::t_acc acc,
                                             logic [3:0] rest);
        return {sel, acc, rest};
    endfunction

    function automatic void counter_load(int idx, logic [7:0] din);
        case (itpe_pkg::t_acc'(tm_mode[idx][5:4]))
            itpe_pkg::ACC_LOW:  tm_reload[idx][7:0] = din;
            itpe_pkg::ACC_HIGH: tm_reload[idx][15:8] = din;
            itpe_pkg::ACC_ALT: begin
                if (tm_tog[idx]) tm_reload[idx][15:8] = din;
                else tm_reload[idx][7:0] = din;
                tm_tog[idx] = ~tm_tog[idx];
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] counter_read(int idx, logic [15:0] end_tick);
        logic [15:0] cnt;
        logic [15:0] elapsed;
        logic [7:0]  rd;
        elapsed = end_tick - tm_start[idx];
        cnt     = tm_reload[idx] + elapsed;
        rd      = 8'h00;
        case (itpe_pkg::t_acc'(tm_mode[idx][5:4]))
            itpe_pkg::ACC_LOW:  rd = cnt[7:0];
            itpe_pkg::ACC_HIGH: rd = cnt[15:8];
            itpe_pkg::ACC_ALT: begin
                rd = tm_tog[idx] ? cnt[15:8] : cnt[7:0];
                tm_tog[idx] = ~tm_tog[idx];
            end
            default: rd = 8'h00;
        endcase
        return rd;
    endfunction

    // applies one bus access or tick to the timer state, returns the byte read back
    function automatic logic [7:0] predict_read_data(itpe_pkg::t_req req, logic [15:0] port,
                                                     logic [7:0] din, logic bsz);
        logic [7:0] rd;
        logic       wr;
        rd = 8'h00;
        wr = (req == itpe_pkg::REQ_WRITE);
        if (req == itpe_pkg::REQ_TICK) begin
            tm_now = tm_now + 16'd1;
        end else if ((req == itpe_pkg::REQ_READ || req == itpe_pkg::REQ_WRITE) && bsz) begin
            case (port)
                itpe_pkg::PORT_CNT0: begin
                    if (wr) begin
                        counter_load(CNT0_IDX, din);
                        tm_start[CNT0_IDX] = tm_now;
                    end else begin
                        rd = counter_read(CNT0_IDX, tm_now);
                    end
                end
                itpe_pkg::PORT_CNT2: begin
                    if (wr) begin
                        counter_load(CNT2_IDX, din);
                        if (tm_gate) tm_start[CNT2_IDX] = tm_now;
                    end else begin
                        rd = counter_read(CNT2_IDX, tm_gate ? tm_now : tm_stop);
                    end
                end
                itpe_pkg::PORT_CTRL: begin
                    if (wr) begin
                        tm_ctrl = din;
                        case (itpe_pkg::t_sel'(din[7:6]))
                            itpe_pkg::SEL_CNT0: begin
                                tm_mode[CNT0_IDX] = din[5:0];
                                tm_tog[CNT0_IDX]  = 1'b0;
                            end
                            itpe_pkg::SEL_CNT2: begin
                                tm_mode[CNT2_IDX] = din[5:0];
                                tm_tog[CNT2_IDX]  = 1'b0;
                            end
                            default: ;
                        endcase
                    end else begin
                        rd = tm_ctrl;
                    end
                end
                itpe_pkg::PORT_B: begin
                    if (wr) begin
                        if (din[0] && !tm_gate) begin
                            tm_start[CNT2_IDX] = tm_now;
                            tm_gate = 1'b1;
                        end else if (!din[0] && tm_gate) begin
                            tm_stop = tm_now;
                            tm_gate = 1'b0;
                        end
                    end else begin
                        rd = {7'b0, tm_gate};
                    end
                end
                default: ;
            endcase
        end
        return rd;
    endfunction

    task automatic send_access(itpe_pkg::t_req req, logic [15:0] port, logic [7:0] din,
                               logic bsz);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.req_type   <= req;
        in_ch.port       <= port;
        in_ch.data       <= din;
        in_ch.byte_sized <= bsz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        read_data_q.push_back(predict_read_data(req, port, din, bsz));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (read_data_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // mostly well-formed timer programming with random content, some noise
    task automatic send_random_access();
        int          pick;
        logic [15:0] port;
        pick = $urandom_range(99);
        port = $urandom_range(1) ? itpe_pkg::PORT_CNT0 : itpe_pkg::PORT_CNT2;
        if (pick < 22) begin
            send_access(itpe_pkg::REQ_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
        end else if (pick < 32) begin
            send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                        ctrl_word($urandom_range(3) == 0 ? itpe_pkg::t_sel'($urandom_range(3))
                                  : ($urandom_range(1) ? itpe_pkg::SEL_CNT0
                                                       : itpe_pkg::SEL_CNT2),
                                  itpe_pkg::t_acc'($urandom_range(3)), 4'($urandom)), 1'b1);
        end else if (pick < 55) begin
            send_access(itpe_pkg::REQ_WRITE, port, 8'($urandom), 1'b1);
        end else if (pick < 75) begin
            send_access(itpe_pkg::REQ_READ, port, 8'($urandom), 1'b1);
        end else if (pick < 82) begin
            send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_B, 8'($urandom), 1'b1);
        end else if (pick < 86) begin
            send_access(itpe_pkg::REQ_READ,
                        $urandom_range(1) ? itpe_pkg::PORT_CTRL : itpe_pkg::PORT_B,
                        8'($urandom), 1'b1);
        end else begin
            case ($urandom_range(3))
                0: port = itpe_pkg::PORT_CNT0;
                1: port = itpe_pkg::PORT_CNT2;
                2: port = itpe_pkg::PORT_CTRL;
                default: port = 16'($urandom);
            endcase
            if ($urandom_range(1)) port = 16'($urandom);
            send_access(itpe_pkg::t_req'($urandom_range(3)), port, 8'($urandom),
                        1'($urandom));
        end
    endtask

    task automatic test_reset_reads();
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT2, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CTRL, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_B, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, 16'hffff, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_NONE, itpe_pkg::PORT_CTRL, 8'hff, 1'b1);
        // not byte sized: ignored, control byte stays zero
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL, 8'hff, 1'b0);
    endtask

    task automatic test_counter0_access();
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_CNT0, itpe_pkg::ACC_ALT, 4'h6), 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT0, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_TICK, 16'h0000, 8'h00, 1'b0);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        // latch access: write still restarts counter 0, read gives zero
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_CNT0, itpe_pkg::ACC_LATCH, 4'h0), 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT0, 8'h55, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
    endtask

    task automatic test_counter2_gate();
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_CNT2, itpe_pkg::ACC_ALT, 4'h0), 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT2, 8'hfe, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT2, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_B, 8'h01, 1'b1);
        send_access(itpe_pkg::REQ_TICK, 16'hffff, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT2, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_B, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_B, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_TICK, 16'h0000, 8'h00, 1'b0);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT2, 8'h00, 1'b1);
        // selectors 1 and 3 only change the stored control byte
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_CNT1, itpe_pkg::ACC_ALT, 4'hf), 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_RB, itpe_pkg::ACC_LATCH, 4'h0), 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CTRL, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_B, 8'h00, 1'b1);
    endtask

    task automatic test_random_traffic(int n_items);
        repeat (n_items) send_random_access();
    endtask

    task automatic test_backpressure_fill();
        hold_armed = 1'b1;
        repeat (40) send_random_access();
    endtask

    // counter values run past 16'hffff and wrap
    task automatic test_tick_wrap();
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CTRL,
                    ctrl_word(itpe_pkg::SEL_CNT0, itpe_pkg::ACC_ALT, 4'h4), 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT0, 8'hfc, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_CNT0, 8'hff, 1'b1);
        send_access(itpe_pkg::REQ_WRITE, itpe_pkg::PORT_B, 8'h01, 1'b1);
        repeat (6) send_access(itpe_pkg::REQ_TICK, 16'($urandom), 8'($urandom),
                               1'($urandom));
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT0, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT2, 8'h00, 1'b1);
        send_access(itpe_pkg::REQ_READ, itpe_pkg::PORT_CNT2, 8'h00, 1'b1);
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (read_data_q.size() == 0) begin
                    $display("%0t: unexpected result read_data=%02h", $time, out_ch.read_data);
                    fail_count++;
                end else begin
                    if (out_ch.read_data !== read_data_q[0]) begin
                        $display("%0t: read_data mismatch expected=%02h actual=%02h",
                                 $time, read_data_q[0], out_ch.read_data);
                        fail_count++;
                    end
                    void'(read_data_q.pop_front());
                end
            end
            if (hold_armed && !hold_taken) begin
                hold_taken   <= 1'b1;
                hold_left    <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.req_type   <= itpe_pkg::REQ_READ;
        in_ch.port       <= '0;
        in_ch.data       <= '0;
        in_ch.byte_sized <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 86;
        test_reset_reads();
        test_counter0_access();
        test_counter2_gate();
        test_random_traffic(580);
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 9;
        test_random_traffic(580);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure_fill();
        test_random_traffic(550);
        test_tick_wrap();
        wait_drained();

        if (fail_count == 0 && read_data_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
